>>> hdl/sjpq_pkg.sv
// Shared types and codes for the shortest-job-first task queue.
`default_nettype none
package sjpq_pkg;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  typedef struct packed {
    logic [15:0] burst_time;
    logic [15:0] arrival_time;
    logic [15:0] task_id;
  } task_t;

  // Packed so that the word matches out_tdata bit for bit.
  typedef struct packed {
    logic [4:0]  occupancy;
    logic        dropped_full;
    logic        was_empty;
    logic        served_valid;
    logic [15:0] served_id;
  } result_t;

  typedef struct packed {
    logic load;    // capture a new result word
    logic do_enq;  // insert the incoming task
    logic do_deq;  // pop the head task
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } dp_status_t;

endpackage
`default_nettype wire

>>> hdl/sjpq_ctrl.sv
// Controller: handshake, output-hold state and datapath commands.
`default_nettype none
module sjpq_ctrl
  import sjpq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic       in_op,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_HOLD = 1'b1;

  logic state_r, state_nxt;
  logic accept;

  assign in_tready  = (state_r == ST_IDLE) || out_tready;
  assign out_tvalid = (state_r == ST_HOLD);
  assign accept     = in_tvalid && in_tready;

  always_comb begin
    cmd.load   = accept;
    cmd.do_enq = accept && (in_op == OP_ENQ) && !status.full;
    cmd.do_deq = accept && (in_op == OP_DEQ) && !status.empty;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_HOLD;
      ST_HOLD: if (!accept && out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.do_enq && cmd.do_deq))
    else $error("enqueue and dequeue issued together");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_deq |-> !status.empty)
    else $error("pop issued on empty queue");

  a_word_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_tvalid)
    else $error("accepted word produced no result");

  a_hold_until_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid)
    else $error("result dropped before it was taken");

endmodule
`default_nettype wire

>>> hdl/sjpq_dpath.sv
// Datapath: sorted shift-register cells, task count and result register.
`default_nettype none
module sjpq_dpath
  import sjpq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire dp_cmd_t cmd,
  input  wire task_t   new_task,
  output dp_status_t   status,
  output result_t      result
);

  localparam int CW = $clog2(CAPACITY + 1);

  task_t          cell_r   [CAPACITY];
  task_t          cell_nxt [CAPACITY];
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [CAPACITY-1:0] go;
  logic [CW+4:0]  cnt_ext;
  result_t        res_r, res_nxt;

  assign status.empty = (cnt_r == '0);
  assign status.full  = (cnt_r == CW'(CAPACITY));

  // A cell takes part in the insert shift when it is free or sorts after the new key.
  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      always_comb begin
        go[g] = (CW'(g) >= cnt_r)
             || (cell_r[g].burst_time > new_task.burst_time)
             || ((cell_r[g].burst_time == new_task.burst_time)
                 && (cell_r[g].arrival_time > new_task.arrival_time));
      end

      if (g == 0) begin : g_head
        always_comb begin
          cell_nxt[g] = cell_r[g];
          if (cmd.do_enq && go[g]) begin
            cell_nxt[g] = new_task;
          end else if (cmd.do_deq) begin
            cell_nxt[g] = cell_r[(CAPACITY > 1) ? 1 : 0];
          end
        end
      end else if (g == CAPACITY - 1) begin : g_tail
        always_comb begin
          cell_nxt[g] = cell_r[g];
          if (cmd.do_enq && go[g]) begin
            cell_nxt[g] = go[g-1] ? cell_r[g-1] : new_task;
          end
        end
      end else begin : g_mid
        always_comb begin
          cell_nxt[g] = cell_r[g];
          if (cmd.do_enq && go[g]) begin
            cell_nxt[g] = go[g-1] ? cell_r[g-1] : new_task;
          end else if (cmd.do_deq) begin
            cell_nxt[g] = cell_r[g+1];
          end
        end
      end

      always_ff @(posedge clk) begin
        cell_r[g] <= cell_nxt[g];
      end
    end
  endgenerate

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.do_enq) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (cmd.do_deq) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  assign cnt_ext = {5'b0, cnt_nxt};

  always_comb begin
    res_nxt.served_id    = cmd.do_deq ? cell_r[0].task_id : 16'h0000;
    res_nxt.served_valid = cmd.do_deq;
    res_nxt.was_empty    = cmd.load && !cmd.do_enq && !cmd.do_deq && status.empty
                           && !status.full;
    res_nxt.dropped_full = cmd.load && !cmd.do_enq && !cmd.do_deq && status.full;
    res_nxt.occupancy    = cnt_ext[4:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_r <= res_nxt;
    end
  end

  assign result = res_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("task count beyond capacity");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_enq |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("insert did not bump count");

  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r > CW'(1)) |-> (cell_r[0].burst_time <= cell_r[1].burst_time))
    else $error("head cells out of order");

endmodule
`default_nettype wire

>>> hdl/shortest_job_priority_queue.sv
// Top level of the shortest-job-first task queue.
//
//  channel | dir | handshake             | payload
//  in_     | in  | in_tvalid / in_tready   | tuser: operation; tdata: id, arrival, burst
//  out_    | out | out_tvalid / out_tready | tdata: id, valid, empty, dropped, occupancy
//
// For each word, all cells compare with the new key at once
// and shift together, and the result lands in a register the next cycle.
// A new word is taken while the held result leaves, so a word per cycle is
// sustained when the output side is ready; a stalled output holds the input.
// Reset (synchronous, active low) empties the queue; cell contents are not cleared.
`default_nettype none
module shortest_job_priority_queue
  import sjpq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // task_id, arrival_time, burst_time
  input  wire logic        in_tuser,   // operation
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata   // served_id, served_valid, was_empty,
                                       // dropped_full, occupancy
);

  dp_cmd_t    cmd;
  dp_status_t status;
  task_t      new_task;
  result_t    result;

  assign new_task.task_id      = in_tdata[15:0];
  assign new_task.arrival_time = in_tdata[31:16];
  assign new_task.burst_time   = in_tdata[47:32];

  sjpq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  sjpq_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .new_task (new_task),
    .status   (status),
    .result   (result)
  );

  assign out_tdata = result;

endmodule
`default_nettype wire
